@@ rtl/core/tccs_pkg.sv @@
`default_nettype none

package tccs_pkg;

  // action codes
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_DEL   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // character and cell constants
  localparam logic [7:0]  NEWLINE_CHAR = 8'd10;
  localparam logic [7:0]  SPACE_CHAR   = 8'h20;
  localparam logic [15:0] BLANK_CELL   = 16'h0020;

  // controller to datapath commands
  typedef struct packed {
    logic latch_in;    // capture a new item
    logic cur_wrap;    // cursor past end: back to start of last row
    logic nl_next;     // newline: start of next row
    logic nl_row;      // newline on last row: start of this row
    logic put_wr;      // write char cell at cursor, advance
    logic del;         // back up and write colored space
    logic clr;         // home the cursor
    logic rd_capture;  // take registered read data
    logic sc_rd;       // scroll: read source cell one row below
    logic sc_wr;       // scroll: write moved cell
    logic wr_blank;    // write blank cell at sweep index
    logic idx_inc;     // advance sweep index
    logic idx_clr;     // restart sweep index
    logic out_load;    // load result register
  } tccs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] act;
    logic       is_nl;
    logic       cur_full;
    logic       cur_zero;
    logic       last_row;
    logic       idx_last_copy;
    logic       idx_last;
    logic       out_busy;
  } tccs_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/text_console_cursor_scroll_top.sv @@
// channel  direction  handshake              payload
// in       input      in_tvalid / in_tready   in_tdata: action, char_code, read_address
// out      output     out_tvalid / out_tready out_tdata: cursor_position, read_data
// cfg      input      cfg_valid / cfg_ready   cfg_data: text_color
//
// one item at a time: read, delete and plain put each end with the output handoff
// newline that scrolls, or put at screen end, is bound by the one memory port: each moved
// cell is read, then written; newline at screen end scrolls twice
// clear blanks every cell; after reset a blanking pass over every cell runs before
// the first item is taken (cfg writes are taken throughout)
// a result waits in the output register while the next item is taken
`default_nettype none

module text_console_cursor_scroll_top #(
  parameter int ROW_COUNT    = 25,
  parameter int COLUMN_COUNT = 80
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // action[1:0], char_code[9:2], read_address[20:10]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // cursor_position[10:0], read_data[26:11]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data    // text_color
);

  localparam int CELL_COUNT = ROW_COUNT * COLUMN_COUNT;

  tccs_pkg::tccs_cmd_t  cmd;
  tccs_pkg::tccs_stat_t st;
  logic [10:0]          cursor_position;
  logic [15:0]          read_data;

  assign cfg_ready = 1'b1;

  tccs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tccs_dp #(
    .ROW_COUNT    (ROW_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_action           (in_tdata[1:0]),
    .in_char_code        (in_tdata[9:2]),
    .in_read_address     (in_tdata[20:10]),
    .cfg_valid           (cfg_valid),
    .cfg_data            (cfg_data),
    .out_ready           (out_tready),
    .out_valid           (out_tvalid),
    .out_cursor_position (cursor_position),
    .out_read_data       (read_data)
  );

  assign out_tdata = {5'b0, read_data, cursor_position};

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken while another is in work");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_tvalid && !out_tready))
    else $error("result register loaded while full");

  // at most one source drives the memory write port
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.put_wr, cmd.del, cmd.wr_blank, cmd.sc_wr}))
    else $error("conflicting memory writes");

  // reported cursor stays on the screen or one past its end
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (CELL_COUNT > 2047) || (32'(out_tdata[10:0]) <= CELL_COUNT))
    else $error("cursor beyond screen");

endmodule

`default_nettype wire

@@ rtl/core/tccs_ram.sv @@
`default_nettype none

module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/tccs_ctrl.sv @@
`default_nettype none

module tccs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tccs_pkg::tccs_stat_t st,
  output tccs_pkg::tccs_cmd_t       cmd
);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_EXEC    = 4'd2;
  localparam logic [3:0] S_PUT     = 4'd3;
  localparam logic [3:0] S_SC_RD   = 4'd4;
  localparam logic [3:0] S_SC_WR   = 4'd5;
  localparam logic [3:0] S_BLANK   = 4'd6;
  localparam logic [3:0] S_CLEAR   = 4'd7;
  localparam logic [3:0] S_RD_WAIT = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       post_put_r, post_put_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      post_put_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      post_put_r <= post_put_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    post_put_nxt = post_put_r;
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      S_INIT, S_CLEAR: begin
        cmd.wr_blank = 1'b1;
        if (st.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = (state_r == S_INIT) ? S_IDLE : S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (st.act)
          tccs_pkg::ACT_PUT: begin
            if (st.cur_full) begin
              cmd.cur_wrap = 1'b1;
              post_put_nxt = 1'b1;
              state_nxt    = S_SC_RD;
            end else begin
              state_nxt = S_PUT;
            end
          end
          tccs_pkg::ACT_DEL: begin
            cmd.del   = !st.cur_zero;
            state_nxt = S_FIN;
          end
          tccs_pkg::ACT_CLEAR: begin
            cmd.clr   = 1'b1;
            state_nxt = S_CLEAR;
          end
          default: begin
            // item address is already on the read port
            state_nxt = S_RD_WAIT;
          end
        endcase
      end
      S_PUT: begin
        if (st.is_nl) begin
          if (st.last_row) begin
            cmd.nl_row   = 1'b1;
            post_put_nxt = 1'b0;
            state_nxt    = S_SC_RD;
          end else begin
            cmd.nl_next = 1'b1;
            state_nxt   = S_FIN;
          end
        end else begin
          cmd.put_wr = 1'b1;
          state_nxt  = S_FIN;
        end
      end
      S_SC_RD: begin
        cmd.sc_rd = 1'b1;
        state_nxt = S_SC_WR;
      end
      S_SC_WR: begin
        cmd.sc_wr   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = st.idx_last_copy ? S_BLANK : S_SC_RD;
      end
      S_BLANK: begin
        cmd.wr_blank = 1'b1;
        if (st.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = post_put_r ? S_PUT : S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_RD_WAIT: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/tccs_dp.sv @@
`default_nettype none

module tccs_dp #(
  parameter int ROW_COUNT    = 25,
  parameter int COLUMN_COUNT = 80
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tccs_pkg::tccs_cmd_t  cmd,
  output tccs_pkg::tccs_stat_t      st,
  input  wire logic [1:0]          in_action,
  input  wire logic [7:0]          in_char_code,
  input  wire logic [10:0]         in_read_address,
  input  wire logic                cfg_valid,
  input  wire logic [7:0]          cfg_data,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic      [10:0]         out_cursor_position,
  output logic      [15:0]         out_read_data
);

  localparam int CELL_COUNT = ROW_COUNT * COLUMN_COUNT;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CUR_W      = $clog2(CELL_COUNT + 1);
  localparam int CW         = $clog2(COLUMN_COUNT);

  localparam logic [CUR_W-1:0] CELL_V     = CUR_W'(CELL_COUNT);
  localparam logic [CUR_W-1:0] LAST_ROW_V = CUR_W'(CELL_COUNT - COLUMN_COUNT);
  localparam logic [CUR_W-1:0] COL_V      = CUR_W'(COLUMN_COUNT);
  localparam logic [CW-1:0]    COL_MAX    = CW'(COLUMN_COUNT - 1);
  localparam logic [AW-1:0]    IDX_COPY_END = AW'(CELL_COUNT - COLUMN_COUNT - 1);
  localparam logic [AW-1:0]    IDX_END      = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0]    ROW_STEP     = AW'(COLUMN_COUNT);

  logic [CUR_W-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [7:0]       color_r;
  logic [1:0]       action_r;
  logic [7:0]       char_r;
  logic [10:0]      addr_r;
  logic             rd_ok_r;
  logic [15:0]      rd_data_r;
  logic             out_valid_r;
  logic [10:0]      out_cursor_r;
  logic [15:0]      out_data_r;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [15:0]      ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [15:0]      ram_rdata;
  logic [CUR_W-1:0] row_start;
  logic [CUR_W-1:0] cursor_dec;

  tccs_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign row_start  = cursor_r - CUR_W'(col_r);
  assign cursor_dec = cursor_r - CUR_W'(1);

  // cell write select
  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = idx_r;
    ram_wdata = tccs_pkg::BLANK_CELL;
    if (cmd.sc_wr) begin
      ram_wdata = ram_rdata;
    end else if (cmd.put_wr) begin
      ram_waddr = AW'(cursor_r);
      ram_wdata = {color_r, char_r};
    end else if (cmd.del) begin
      ram_waddr = AW'(cursor_dec);
      ram_wdata = {color_r, tccs_pkg::SPACE_CHAR};
    end else if (!cmd.wr_blank) begin
      ram_we = 1'b0;
    end
  end

  // read address: scroll source or item address
  assign ram_raddr = cmd.sc_rd ? (idx_r + ROW_STEP) : AW'(addr_r);

  // cursor, column and sweep index
  always_comb begin
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    if (cmd.cur_wrap) begin
      cursor_nxt = LAST_ROW_V;
      col_nxt    = '0;
    end else if (cmd.nl_row) begin
      cursor_nxt = row_start;
      col_nxt    = '0;
    end else if (cmd.nl_next) begin
      cursor_nxt = cursor_r + (COL_V - CUR_W'(col_r));
      col_nxt    = '0;
    end else if (cmd.put_wr) begin
      cursor_nxt = cursor_r + CUR_W'(1);
      col_nxt    = (col_r == COL_MAX) ? '0 : col_r + CW'(1);
    end else if (cmd.del) begin
      cursor_nxt = cursor_dec;
      col_nxt    = (col_r == '0) ? COL_MAX : col_r - CW'(1);
    end else if (cmd.clr) begin
      cursor_nxt = '0;
      col_nxt    = '0;
    end
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + AW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      col_r       <= '0;
      idx_r       <= '0;
      color_r     <= 8'd15;
      out_valid_r <= 1'b0;
    end else begin
      cursor_r <= cursor_nxt;
      col_r    <= col_nxt;
      idx_r    <= idx_nxt;
      if (cfg_valid) begin
        color_r <= cfg_data;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      action_r  <= in_action;
      char_r    <= in_char_code;
      addr_r    <= in_read_address;
      rd_ok_r   <= (32'(in_read_address) < CELL_COUNT);
      rd_data_r <= '0;
    end else if (cmd.rd_capture) begin
      rd_data_r <= rd_ok_r ? ram_rdata : '0;
    end
    if (cmd.out_load) begin
      out_cursor_r <= 11'(cursor_r);
      out_data_r   <= rd_data_r;
    end
  end

  // status
  always_comb begin
    st.act           = action_r;
    st.is_nl         = (char_r == tccs_pkg::NEWLINE_CHAR);
    st.cur_full      = (cursor_r >= CELL_V);
    st.cur_zero      = (cursor_r == '0);
    st.last_row      = (row_start >= LAST_ROW_V);
    st.idx_last_copy = (idx_r == IDX_COPY_END);
    st.idx_last      = (idx_r == IDX_END);
    st.out_busy      = out_valid_r & ~out_ready;
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_cursor_r;
  assign out_read_data       = out_data_r;

endmodule

`default_nettype wire
